[sv/sobel_edge_magnitude_3x3_assert.svh]
// Assertion macros shared by the Sobel edge magnitude checker.
`ifndef SOBEL_EDGE_MAGNITUDE_3X3_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_3X3_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SEM_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sem assertion failed");

// Next-cycle implication, disabled during reset.
`define SEM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sem assertion failed");

// Next-cycle implication that is also checked across reset.
`define SEM_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("sem assertion failed");

`endif

[sv/sem_pkg.sv]
// Types, constants and arithmetic helpers of the Sobel edge magnitude block.
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int MAX_HEIGHT_DEFAULT = 4096;
   localparam int QUEUE_DEPTH        = 4;
   localparam int RESET_WIDTH        = 1024;
   localparam int RESET_HEIGHT       = 768;
   localparam int CLAMP_LIMIT        = 65280;

   localparam logic [7:0] CSR_FRAME_WIDTH  = 8'd0;
   localparam logic [7:0] CSR_FRAME_HEIGHT = 8'd1;

   typedef logic [23:0] pixel_type;
   typedef logic [8:0][23:0] window_type;
   typedef logic signed [10:0] grad_type;

   typedef struct packed {
      logic       operation;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] edge_red;
      logic [7:0] edge_green;
      logic [7:0] edge_blue;
      logic       frame_last;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0]  index;
      logic [15:0] data;
   } csr_payload_type;

   typedef struct packed {
      logic      valid;
      logic      clear;
      logic      has_top;
      logic      has_mid;
      logic      emit;
      logic      mask_left;
      logic      mask_right;
      logic      last;
      pixel_type pix;
   } line_ctl_type;

   typedef struct packed {
      grad_type [2:0] gx;
      grad_type [2:0] gy;
      logic           last;
   } entry_type;

   typedef struct packed {
      logic [16:0] rem;
      logic [16:0] root;
   } sqrt_type;

   function automatic grad_type cell_val(window_type win, int idx, int chan, logic masked);
      logic [7:0] v;
      v = win[idx][23 - 8 * chan -: 8];
      return masked ? grad_type'(0) : grad_type'({3'b000, v});
   endfunction

   function automatic entry_type gradients(window_type win, logic ml, logic mr, logic last);
      entry_type e;
      grad_type  c0, c1, c2, c3, c5, c6, c7, c8;
      e.last = last;
      for (int c = 0; c < 3; c++) begin
         c0 = cell_val(win, 0, c, ml);
         c1 = cell_val(win, 1, c, 1'b0);
         c2 = cell_val(win, 2, c, mr);
         c3 = cell_val(win, 3, c, ml);
         c5 = cell_val(win, 5, c, mr);
         c6 = cell_val(win, 6, c, ml);
         c7 = cell_val(win, 7, c, 1'b0);
         c8 = cell_val(win, 8, c, mr);
         e.gx[c] = (c2 + (c5 <<< 1) + c8) - (c0 + (c3 <<< 1) + c6);
         e.gy[c] = (c6 + (c7 <<< 1) + c8) - (c0 + (c1 <<< 1) + c2);
      end
      return e;
   endfunction

   function automatic sqrt_type sqrt_step(sqrt_type cur, logic [16:0] bitv);
      sqrt_type nxt;
      if (cur.rem >= cur.root + bitv) begin
         nxt.rem  = cur.rem - (cur.root + bitv);
         nxt.root = (cur.root >> 1) + bitv;
      end else begin
         nxt.rem  = cur.rem;
         nxt.root = cur.root >> 1;
      end
      return nxt;
   endfunction

endpackage
`default_nettype wire

[sv/sem_stream_if.sv]
// Valid/ready channel interface carrying one payload type.
`timescale 1ns / 1ps
`default_nettype none
interface sem_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[sv/sem_front.sv]
// Front end: accepts pixels and register writes, tracks frame position.
`timescale 1ns / 1ps
`default_nettype none
module sem_front #(
   parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire sem_pkg::req_payload_type       req_payload,
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire sem_pkg::csr_payload_type       csr_payload,
   input  wire logic                           queue_room,
   output      logic                           rd_en,
   output      logic [$clog2(MAX_WIDTH)-1:0]   rd_addr,
   output      logic [$clog2(MAX_WIDTH)-1:0]   wr_addr,
   output      sem_pkg::line_ctl_type          line_ctl
);
   localparam int IW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 2);

   logic [WW-1:0] width_ff;
   logic [HW-1:0] height_ff;
   logic [IW-1:0] icol_ff, icol_in, icol_use;
   logic [HW-1:0] irow_ff, irow_in;
   logic [IW-1:0] ocol_ff, ocol_in;
   logic [HW-1:0] orow_ff, orow_in;
   logic [IW-1:0] addr_ff;
   sem_pkg::line_ctl_type ctl_ff, ctl_in, clear_ctl;
   logic fire, drop, in_frame, csr_fire;

   function automatic logic [WW-1:0] clamp_w(logic [10:0] v);
      if (v == '0) return WW'(1);
      if (32'(v) > MAX_WIDTH) return WW'(MAX_WIDTH);
      return WW'(v);
   endfunction

   function automatic logic [HW-1:0] clamp_h(logic [12:0] v);
      if (v == '0) return HW'(1);
      if (32'(v) > MAX_HEIGHT) return HW'(MAX_HEIGHT);
      return HW'(v);
   endfunction

   // A register write takes priority over a pixel transfer in the same cycle.
   assign req_ready = queue_room && !csr_valid;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign fire      = req_valid && req_ready;
   assign in_frame  = irow_ff < height_ff;
   assign drop      = req_payload.operation && in_frame;
   assign rd_en     = fire && !drop;
   assign rd_addr   = icol_use;
   assign wr_addr   = addr_ff;
   assign line_ctl  = ctl_ff;

   always_comb begin
      clear_ctl         = '0;
      clear_ctl.clear   = 1'b1;
      icol_use = (WW'(icol_ff) >= width_ff) ? '0 : icol_ff;
      ctl_in.valid      = fire && !drop;
      ctl_in.clear      = 1'b0;
      ctl_in.has_top    = irow_ff >= HW'(2);
      ctl_in.has_mid    = irow_ff >= HW'(1);
      ctl_in.emit       = (irow_ff >= HW'(2)) || ((irow_ff == HW'(1)) && (icol_use != '0));
      ctl_in.mask_left  = ocol_ff == '0;
      ctl_in.mask_right = (WW'(ocol_ff) + WW'(1)) >= width_ff;
      ctl_in.last       = ctl_in.mask_right && ((orow_ff + HW'(1)) >= height_ff);
      ctl_in.pix        = in_frame ? {req_payload.in_red, req_payload.in_green,
                                      req_payload.in_blue} : '0;
      if ((WW'(icol_use) + WW'(1)) >= width_ff) begin
         icol_in = '0;
         irow_in = irow_ff + HW'(1);
      end else begin
         icol_in = icol_use + IW'(1);
         irow_in = irow_ff;
      end
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      if (ctl_in.emit) begin
         if (ctl_in.mask_right) begin
            ocol_in = '0;
            orow_in = orow_ff + HW'(1);
         end else begin
            ocol_in = ocol_ff + IW'(1);
         end
      end
      if (ctl_in.emit && ctl_in.last) begin
         icol_in = '0;
         irow_in = '0;
         ocol_in = '0;
         orow_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= icol_use;
      if (reset) begin
         width_ff  <= clamp_w(11'(sem_pkg::RESET_WIDTH));
         height_ff <= clamp_h(13'(sem_pkg::RESET_HEIGHT));
         icol_ff   <= '0;
         irow_ff   <= '0;
         ocol_ff   <= '0;
         orow_ff   <= '0;
         ctl_ff    <= '0;
      end else if (csr_fire) begin
         if (csr_payload.index == sem_pkg::CSR_FRAME_WIDTH) begin
            width_ff <= clamp_w(csr_payload.data[10:0]);
         end
         if (csr_payload.index == sem_pkg::CSR_FRAME_HEIGHT) begin
            height_ff <= clamp_h(csr_payload.data[12:0]);
         end
         if ((csr_payload.index == sem_pkg::CSR_FRAME_WIDTH) ||
             (csr_payload.index == sem_pkg::CSR_FRAME_HEIGHT)) begin
            icol_ff <= '0;
            irow_ff <= '0;
            ocol_ff <= '0;
            orow_ff <= '0;
            ctl_ff  <= clear_ctl;
         end else begin
            ctl_ff <= '0;
         end
      end else begin
         ctl_ff <= ctl_in;
         if (ctl_in.valid) begin
            icol_ff <= icol_in;
            irow_ff <= irow_in;
            ocol_ff <= ocol_in;
            orow_ff <= orow_in;
         end
      end
   end
endmodule
`default_nettype wire

[sv/sem_line.sv]
// Line stores and 3x3 window; produces Sobel gradients for each result.
`timescale 1ns / 1ps
`default_nettype none
module sem_line #(
   parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         rd_en,
   input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  wire sem_pkg::line_ctl_type        line_ctl,
   output      logic                         push,
   output      sem_pkg::entry_type           push_data
);
   logic [47:0] mem [MAX_WIDTH];
   logic [47:0] rd_ff, wr_data;
   sem_pkg::pixel_type  top, mid;
   sem_pkg::window_type win_ff, win_shift;
   logic we;

   assign we      = line_ctl.valid;
   assign top     = line_ctl.has_top ? rd_ff[47:24] : '0;
   assign mid     = line_ctl.has_mid ? rd_ff[23:0] : '0;
   assign wr_data = {mid, line_ctl.pix};

   always_comb begin
      win_shift = win_ff;
      for (int r = 0; r < 3; r++) begin
         win_shift[r * 3 + 0] = win_ff[r * 3 + 1];
         win_shift[r * 3 + 1] = win_ff[r * 3 + 2];
      end
      win_shift[2] = top;
      win_shift[5] = mid;
      win_shift[8] = line_ctl.pix;
   end

   assign push      = line_ctl.valid && line_ctl.emit;
   assign push_data = sem_pkg::gradients(win_shift, line_ctl.mask_left,
                                         line_ctl.mask_right, line_ctl.last);

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= (we && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || line_ctl.clear) begin
         win_ff <= '0;
      end else if (line_ctl.valid) begin
         win_ff <= (line_ctl.emit && line_ctl.last) ? '0 : win_shift;
      end
   end
endmodule
`default_nettype wire

[sv/sem_queue.sv]
// Short queue of gradient entries between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module sem_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire sem_pkg::entry_type push_data,
   input  wire logic               pop,
   output      sem_pkg::entry_type head,
   output      logic               not_empty,
   output      logic               room
);
   localparam int DEPTH = sem_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   sem_pkg::entry_type slots_ff [DEPTH];
   logic [PW-1:0] wptr_ff, rptr_ff;
   logic [CW-1:0] count_ff;

   assign head      = slots_ff[rptr_ff];
   assign not_empty = count_ff != '0;
   // Two free slots cover the item still in the line stage.
   assign room      = count_ff <= CW'(DEPTH - 2);

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + PW'(1);
         end
         if (pop) begin
            rptr_ff <= (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + PW'(1);
         end
         count_ff <= count_ff + CW'(push) - CW'(pop);
      end
   end
endmodule
`default_nettype wire

[sv/sem_back.sv]
// Back end: squares, rounded integer square root, clamp and result register.
`timescale 1ns / 1ps
`default_nettype none
module sem_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sem_pkg::entry_type head,
   input  wire logic               not_empty,
   output      logic               pop,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      sem_pkg::rsp_payload_type rsp_payload
);
   logic        enable;
   logic        v1_ff, v2_ff, v3_ff;
   logic        last1_ff, last2_ff;
   logic [19:0] sqx_ff [3];
   logic [19:0] sqy_ff [3];
   logic [20:0] sum [3];
   logic [2:0]  big_ff;
   sem_pkg::sqrt_type s2_in [3];
   sem_pkg::sqrt_type s2_ff [3];
   sem_pkg::sqrt_type s3 [3];
   logic [7:0]  mag [3];
   logic signed [21:0] px [3];
   logic signed [21:0] py [3];
   sem_pkg::rsp_payload_type out_ff;

   assign enable      = !v3_ff || rsp_ready;
   assign pop         = enable && not_empty;
   assign rsp_valid   = v3_ff;
   assign rsp_payload = out_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         px[c]  = head.gx[c] * head.gx[c];
         py[c]  = head.gy[c] * head.gy[c];
         sum[c] = 21'(sqx_ff[c]) + 21'(sqy_ff[c]);
         s2_in[c].rem  = {1'b0, sum[c][15:0]};
         s2_in[c].root = '0;
         for (int k = 0; k < 4; k++) begin
            s2_in[c] = sem_pkg::sqrt_step(s2_in[c], 17'(1) << (14 - 2 * k));
         end
         s3[c] = s2_ff[c];
         for (int k = 4; k < 8; k++) begin
            s3[c] = sem_pkg::sqrt_step(s3[c], 17'(1) << (14 - 2 * k));
         end
         if (big_ff[c]) begin
            mag[c] = 8'hFF;
         end else if (s3[c].rem > s3[c].root) begin
            mag[c] = s3[c].root[7:0] + 8'd1;
         end else begin
            mag[c] = s3[c].root[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         last1_ff <= head.last;
         last2_ff <= last1_ff;
         for (int c = 0; c < 3; c++) begin
            sqx_ff[c] <= px[c][19:0];
            sqy_ff[c] <= py[c][19:0];
            big_ff[c] <= sum[c] > 21'(sem_pkg::CLAMP_LIMIT);
            s2_ff[c]  <= s2_in[c];
         end
         out_ff.edge_red   <= mag[0];
         out_ff.edge_green <= mag[1];
         out_ff.edge_blue  <= mag[2];
         out_ff.frame_last <= last2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= not_empty;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end
endmodule
`default_nettype wire

[sv/sobel_edge_magnitude_3x3.sv]
// Top level of the streaming 3x3 Sobel edge magnitude block.
// Throughput: one pixel or flush transfer per cycle while the queue has room and no register write is pending.
// Path: the transfer that completes a result's window, which is one line plus one pixel after its own pixel,
// is registered in the front end, queued, then passes the square, root and result registers.
// Reset: synchronous; counters, window and queue clear at once, line stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sobel_edge_magnitude_3x3 #(
   parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEFAULT
) (
   input wire logic    clock,
   input wire logic    reset,
   sem_stream_if.sink   req_if,
   sem_stream_if.source rsp_if,
   sem_stream_if.sink   csr_if
);
   localparam int IW = $clog2(MAX_WIDTH);

   logic rd_en, push, pop, not_empty, room;
   logic [IW-1:0] rd_addr, wr_addr;
   sem_pkg::line_ctl_type line_ctl;
   sem_pkg::entry_type push_data, head;

   sem_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_if.valid), .req_ready(req_if.ready), .req_payload(req_if.payload),
      .csr_valid(csr_if.valid), .csr_ready(csr_if.ready), .csr_payload(csr_if.payload),
      .queue_room(room), .rd_en(rd_en), .rd_addr(rd_addr), .wr_addr(wr_addr),
      .line_ctl(line_ctl)
   );

   sem_line #(.MAX_WIDTH(MAX_WIDTH)) u_line (
      .clock(clock), .reset(reset), .rd_en(rd_en), .rd_addr(rd_addr),
      .wr_addr(wr_addr), .line_ctl(line_ctl), .push(push), .push_data(push_data)
   );

   sem_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data),
      .pop(pop), .head(head), .not_empty(not_empty), .room(room)
   );

   sem_back u_back (
      .clock(clock), .reset(reset), .head(head), .not_empty(not_empty), .pop(pop),
      .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready), .rsp_payload(rsp_if.payload)
   );
endmodule
`default_nettype wire

[sv/sem_checker.sv]
// Port-level checker for the Sobel edge magnitude block and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "sobel_edge_magnitude_3x3_assert.svh"
module sem_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire sem_pkg::rsp_payload_type rsp_payload,
   input wire logic                     csr_ready
);
   `SEM_ASSERT_NEXT(rsp_valid_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `SEM_ASSERT_NEXT(rsp_payload_held, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_payload))
   `SEM_ASSERT_NEXT_ALWAYS(rsp_idle_after_reset, clock, reset, !rsp_valid)
   `SEM_ASSERT_SAME(csr_always_ready, clock, reset, 1'b1, csr_ready)
endmodule

bind sobel_edge_magnitude_3x3 sem_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready),
   .rsp_payload(rsp_if.payload), .csr_ready(csr_if.ready)
);
`default_nettype wire
